@@ rtl/rsp_pkg.sv @@
// Shared types and constants for the road segment projector.
// Used by rsp_arith and road_segment_projector; depends on nothing.
package rsp_pkg;

    // Fraction bits of the perspective scale (Q format of depth_scale).
    localparam int SCALE_FRAC_BITS = 24;

    // Field widths fixed by the interface.
    localparam int SCALE_W    = 24;
    localparam int SW_W       = 13;
    localparam int SH_W       = 13;
    localparam int RW_W       = 16;
    localparam int CDEPTH_W   = 18;
    localparam int CFG_DATA_W = 18;
    localparam int CFG_IDX_W  = 2;

    // Shared arithmetic unit sizing.
    localparam int ACC_W    = 64;
    localparam int OPB_W    = 24;
    localparam int CNT_W    = 6;
    localparam int DIV_BITS = SCALE_FRAC_BITS + 2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROAD_WIDTH    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CAMERA_DEPTH  = 2'd3;

    // Reset values of the configuration registers.
    localparam logic [SW_W-1:0]     SCREEN_WIDTH_RST  = 13'd1024;
    localparam logic [SH_W-1:0]     SCREEN_HEIGHT_RST = 13'd768;
    localparam logic [RW_W-1:0]     ROAD_WIDTH_RST    = 16'd2000;
    localparam logic [CDEPTH_W-1:0] CAMERA_DEPTH_RST  = 18'd55050;

    // Operations of the shared unit.
    typedef enum logic {
        OP_MUL,
        OP_DIV
    } arith_op_t;

    // Command from the sequencer to the shared unit.
    typedef struct packed {
        logic             start;
        arith_op_t        op;
        logic [ACC_W-1:0] a;
        logic [OPB_W-1:0] b;
        logic [CNT_W-1:0] nbits;
    } arith_cmd_t;

    // Status from the shared unit back to the sequencer.
    typedef struct packed {
        logic busy;
        logic done;
    } arith_stat_t;

endpackage

@@ rtl/road_segment_projector.sv @@
// Road segment projector: each item runs one restoring divide of SCALE_FRAC_BITS + 2 steps
// and six shift-add multiplies in the shared unit; a segment behind the camera skips them,
// and output stalls hold the block back. A new segment is taken only once the last result
// word has moved into the output register.
// Reset clears the curve accumulators, loads the horizon with 768 and restores
// the configuration registers to their defaults; no output word is pending after reset.
module road_segment_projector
    import rsp_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    // Configuration write port.
    input  logic                        cfg_write,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [CFG_DATA_W-1:0]       cfg_data,
    // Segment input channel.
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic                        frame_start,
    input  logic signed [23:0]          player_x,
    input  logic signed [15:0]          camera_height,
    input  logic signed [23:0]          camera_z,
    input  logic signed [15:0]          center_x,
    input  logic signed [15:0]          center_y,
    input  logic [22:0]                 center_z,
    input  logic signed [9:0]           bend,
    // Projection output channel.
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic signed [15:0]          screen_x,
    output logic signed [15:0]          screen_y,
    output logic [15:0]                 road_half_width,
    output logic [SCALE_W-1:0]          depth_scale,
    output logic signed [15:0]          clip_line,
    output logic                        visible,
    output logic                        behind_camera
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIV,
        S_MX,
        S_NX,
        S_MY,
        S_NY,
        S_MW,
        S_NW,
        S_DONE
    } state_t;

    localparam logic signed [40:0] DXQ_LIM = {2'b00, {39{1'b1}}};

    state_t state_reg, state_next;

    // Configuration registers.
    logic [SW_W-1:0]      screen_width_reg, screen_width_next;
    logic [SH_W-1:0]      screen_height_reg, screen_height_next;
    logic [RW_W-1:0]      road_width_reg, road_width_next;
    logic [CDEPTH_W-1:0]  camera_depth_reg, camera_depth_next;

    // Running state across segments.
    logic [39:0]          curve_offset_reg, curve_offset_next;
    logic [31:0]          curve_rate_reg, curve_rate_next;
    logic signed [15:0]   horizon_reg, horizon_next;

    // Per-segment working registers.
    logic signed [39:0]   dxq_reg, dxq_next;
    logic signed [16:0]   dy_reg, dy_next;
    logic signed [15:0]   work_sx_reg, work_sx_next;
    logic signed [15:0]   work_sy_reg, work_sy_next;
    logic [15:0]          work_half_reg, work_half_next;
    logic [SCALE_W-1:0]   work_scale_reg, work_scale_next;
    logic signed [15:0]   work_clip_reg, work_clip_next;
    logic                 work_vis_reg, work_vis_next;
    logic                 work_behind_reg, work_behind_next;

    // Output word registers.
    logic                 out_valid_reg, out_valid_next;
    logic signed [15:0]   screen_x_reg, screen_x_next;
    logic signed [15:0]   screen_y_reg, screen_y_next;
    logic [15:0]          half_reg, half_next;
    logic [SCALE_W-1:0]   scale_reg, scale_next;
    logic signed [15:0]   clip_reg, clip_next;
    logic                 vis_reg, vis_next;
    logic                 behind_reg, behind_next;

    // Shared unit interface.
    arith_cmd_t              arith_cmd;
    arith_stat_t             arith_stat;
    logic signed [ACC_W-1:0] arith_res;

    // Input-side combinational values.
    logic                 in_accept;
    logic [39:0]          off_eff;
    logic [31:0]          rate_eff;
    logic signed [15:0]   hor_eff;
    logic signed [24:0]   dz;
    logic                 behind_in;
    logic signed [24:0]   lat;
    logic signed [40:0]   dxq_raw;
    logic signed [39:0]   dxq_sat;
    logic signed [16:0]   dy_in;

    // Result-side combinational values.
    logic [SCALE_W-1:0]      scale_sat;
    logic signed [ACC_W-1:0] tx_plus;
    logic signed [ACC_W-1:0] ty_minus;
    logic signed [ACC_W-1:0] pix_shift;
    logic signed [15:0]      pix_sat;
    logic [ACC_W-1:0]        half_shift;
    logic [15:0]             half_sat;
    logic                    out_free;

    function automatic logic signed [15:0] sat16(input logic signed [ACC_W-1:0] v);
        if (v > 64'sd32767)
            return 16'sd32767;
        else if (v < -64'sd32768)
            return 16'sh8000;
        else
            return v[15:0];
    endfunction

    rsp_arith u_arith (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (arith_cmd),
        .stat   (arith_stat),
        .result (arith_res)
    );

    assign in_stall  = (state_reg != S_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;

    // A frame start clears the accumulators and reloads the horizon before this segment.
    assign off_eff  = frame_start ? 40'd0 : curve_offset_reg;
    assign rate_eff = frame_start ? 32'd0 : curve_rate_reg;
    assign hor_eff  = frame_start ? $signed({3'b000, screen_height_reg}) : horizon_reg;

    // Depth ahead of the camera; zero or negative means behind it.
    assign dz        = $signed({2'b00, center_z}) - $signed({camera_z[23], camera_z});
    assign behind_in = dz[24] || (dz == 25'sd0);

    // Lateral distance in Q8 including the curve offset, clamped symmetrically.
    assign lat     = $signed({{9{center_x[15]}}, center_x}) - $signed({player_x[23], player_x});
    assign dxq_raw = $signed({{8{lat[24]}}, lat, 8'h00}) + $signed({off_eff[39], off_eff});
    always_comb
    begin
        if (dxq_raw > DXQ_LIM)
            dxq_sat = DXQ_LIM[39:0];
        else if (dxq_raw < -DXQ_LIM)
            dxq_sat = 40'(-DXQ_LIM);
        else
            dxq_sat = dxq_raw[39:0];
    end

    assign dy_in = $signed({center_y[15], center_y}) - $signed({camera_height[15], camera_height});

    // Post-processing of the shared unit's result for each step.
    assign scale_sat  = (|arith_res[ACC_W-1:SCALE_W]) ? {SCALE_W{1'b1}}
                                                      : arith_res[SCALE_W-1:0];
    assign tx_plus    = (arith_res >>> SCALE_FRAC_BITS) + 64'sd256;
    assign ty_minus   = 64'sd256 - (arith_res >>> (SCALE_FRAC_BITS - 8));
    assign pix_shift  = arith_res >>> 9;
    assign pix_sat    = sat16(pix_shift);
    assign half_shift = $unsigned(arith_res) >> (SCALE_FRAC_BITS + 1);
    assign half_sat   = (|half_shift[ACC_W-1:16]) ? 16'hFFFF : half_shift[15:0];

    // Sequencer: issues each step to the shared unit and collects its result.
    always_comb
    begin
        state_next         = state_reg;
        screen_width_next  = screen_width_reg;
        screen_height_next = screen_height_reg;
        road_width_next    = road_width_reg;
        camera_depth_next  = camera_depth_reg;
        curve_offset_next  = curve_offset_reg;
        curve_rate_next    = curve_rate_reg;
        horizon_next       = horizon_reg;
        dxq_next           = dxq_reg;
        dy_next            = dy_reg;
        work_sx_next       = work_sx_reg;
        work_sy_next       = work_sy_reg;
        work_half_next     = work_half_reg;
        work_scale_next    = work_scale_reg;
        work_clip_next     = work_clip_reg;
        work_vis_next      = work_vis_reg;
        work_behind_next   = work_behind_reg;
        out_valid_next     = out_valid_reg && out_stall;
        screen_x_next      = screen_x_reg;
        screen_y_next      = screen_y_reg;
        half_next          = half_reg;
        scale_next         = scale_reg;
        clip_next          = clip_reg;
        vis_next           = vis_reg;
        behind_next        = behind_reg;
        arith_cmd          = '0;
        arith_cmd.op       = OP_MUL;

        // Configuration writes.
        if (cfg_write)
        begin
            case (cfg_index)
                CFG_SCREEN_WIDTH:  screen_width_next  = cfg_data[SW_W-1:0];
                CFG_SCREEN_HEIGHT: screen_height_next = cfg_data[SH_W-1:0];
                CFG_ROAD_WIDTH:    road_width_next    = cfg_data[RW_W-1:0];
                CFG_CAMERA_DEPTH:  camera_depth_next  = cfg_data[CDEPTH_W-1:0];
                default:           ;
            endcase
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    // Accumulators advance once per segment, visible or not.
                    curve_offset_next = off_eff + {{8{rate_eff[31]}}, rate_eff};
                    curve_rate_next   = rate_eff + {{22{bend[9]}}, bend};
                    horizon_next      = hor_eff;
                    work_clip_next    = hor_eff;
                    dxq_next          = dxq_sat;
                    dy_next           = dy_in;
                    work_behind_next  = behind_in;
                    work_vis_next     = 1'b0;
                    if (behind_in)
                    begin
                        work_sx_next    = '0;
                        work_sy_next    = '0;
                        work_half_next  = '0;
                        work_scale_next = '0;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        // Scale = camera_depth * 2^(frac-16) / depth, numerator left-aligned.
                        arith_cmd.start = 1'b1;
                        arith_cmd.op    = OP_DIV;
                        arith_cmd.a     = {camera_depth_reg, {(ACC_W-CDEPTH_W){1'b0}}};
                        arith_cmd.b     = dz[OPB_W-1:0];
                        arith_cmd.nbits = CNT_W'(DIV_BITS);
                        state_next      = S_DIV;
                    end
                end
            end
            S_DIV:
            begin
                if (arith_stat.done)
                begin
                    work_scale_next = scale_sat;
                    arith_cmd.start = 1'b1;
                    arith_cmd.a     = {{(ACC_W-40){dxq_reg[39]}}, dxq_reg};
                    arith_cmd.b     = scale_sat;
                    arith_cmd.nbits = CNT_W'(SCALE_W);
                    state_next      = S_MX;
                end
            end
            S_MX:
            begin
                if (arith_stat.done)
                begin
                    arith_cmd.start = 1'b1;
                    arith_cmd.a     = tx_plus;
                    arith_cmd.b     = {{(OPB_W-SW_W){1'b0}}, screen_width_reg};
                    arith_cmd.nbits = CNT_W'(SW_W);
                    state_next      = S_NX;
                end
            end
            S_NX:
            begin
                if (arith_stat.done)
                begin
                    work_sx_next    = pix_sat;
                    arith_cmd.start = 1'b1;
                    arith_cmd.a     = {{(ACC_W-17){dy_reg[16]}}, dy_reg};
                    arith_cmd.b     = work_scale_reg;
                    arith_cmd.nbits = CNT_W'(SCALE_W);
                    state_next      = S_MY;
                end
            end
            S_MY:
            begin
                if (arith_stat.done)
                begin
                    arith_cmd.start = 1'b1;
                    arith_cmd.a     = ty_minus;
                    arith_cmd.b     = {{(OPB_W-SH_W){1'b0}}, screen_height_reg};
                    arith_cmd.nbits = CNT_W'(SH_W);
                    state_next      = S_NY;
                end
            end
            S_NY:
            begin
                if (arith_stat.done)
                begin
                    // A segment above the current horizon is drawn and lowers the horizon.
                    work_sy_next = pix_sat;
                    if (pix_sat < horizon_reg)
                    begin
                        work_vis_next = 1'b1;
                        horizon_next  = pix_sat;
                    end
                    arith_cmd.start = 1'b1;
                    arith_cmd.a     = {{(ACC_W-SCALE_W){1'b0}}, work_scale_reg};
                    arith_cmd.b     = {{(OPB_W-RW_W){1'b0}}, road_width_reg};
                    arith_cmd.nbits = CNT_W'(RW_W);
                    state_next      = S_MW;
                end
            end
            S_MW:
            begin
                if (arith_stat.done)
                begin
                    arith_cmd.start = 1'b1;
                    arith_cmd.a     = arith_res;
                    arith_cmd.b     = {{(OPB_W-SW_W){1'b0}}, screen_width_reg};
                    arith_cmd.nbits = CNT_W'(SW_W);
                    state_next      = S_NW;
                end
            end
            S_NW:
            begin
                if (arith_stat.done)
                begin
                    work_half_next = half_sat;
                    state_next     = S_DONE;
                end
            end
            S_DONE:
            begin
                // Hand the word to the output register once it is free.
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    screen_x_next  = work_sx_reg;
                    screen_y_next  = work_sy_reg;
                    half_next      = work_half_reg;
                    scale_next     = work_scale_reg;
                    clip_next      = work_clip_reg;
                    vis_next       = work_vis_reg;
                    behind_next    = work_behind_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            screen_width_reg  <= SCREEN_WIDTH_RST;
            screen_height_reg <= SCREEN_HEIGHT_RST;
            road_width_reg    <= ROAD_WIDTH_RST;
            camera_depth_reg  <= CAMERA_DEPTH_RST;
            curve_offset_reg  <= '0;
            curve_rate_reg    <= '0;
            horizon_reg       <= $signed({3'b000, SCREEN_HEIGHT_RST});
            dxq_reg           <= '0;
            dy_reg            <= '0;
            work_sx_reg       <= '0;
            work_sy_reg       <= '0;
            work_half_reg     <= '0;
            work_scale_reg    <= '0;
            work_clip_reg     <= '0;
            work_vis_reg      <= 1'b0;
            work_behind_reg   <= 1'b0;
            out_valid_reg     <= 1'b0;
            screen_x_reg      <= '0;
            screen_y_reg      <= '0;
            half_reg          <= '0;
            scale_reg         <= '0;
            clip_reg          <= '0;
            vis_reg           <= 1'b0;
            behind_reg        <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            screen_width_reg  <= screen_width_next;
            screen_height_reg <= screen_height_next;
            road_width_reg    <= road_width_next;
            camera_depth_reg  <= camera_depth_next;
            curve_offset_reg  <= curve_offset_next;
            curve_rate_reg    <= curve_rate_next;
            horizon_reg       <= horizon_next;
            dxq_reg           <= dxq_next;
            dy_reg            <= dy_next;
            work_sx_reg       <= work_sx_next;
            work_sy_reg       <= work_sy_next;
            work_half_reg     <= work_half_next;
            work_scale_reg    <= work_scale_next;
            work_clip_reg     <= work_clip_next;
            work_vis_reg      <= work_vis_next;
            work_behind_reg   <= work_behind_next;
            out_valid_reg     <= out_valid_next;
            screen_x_reg      <= screen_x_next;
            screen_y_reg      <= screen_y_next;
            half_reg          <= half_next;
            scale_reg         <= scale_next;
            clip_reg          <= clip_next;
            vis_reg           <= vis_next;
            behind_reg        <= behind_next;
        end
    end

    // Output word.
    assign out_valid       = out_valid_reg;
    assign screen_x        = screen_x_reg;
    assign screen_y        = screen_y_reg;
    assign road_half_width = half_reg;
    assign depth_scale     = scale_reg;
    assign clip_line       = clip_reg;
    assign visible         = vis_reg;
    assign behind_camera   = behind_reg;

    // The shared unit only finishes a step while the sequencer waits on it.
    a_done_in_step: assert property (@(posedge clk) disable iff (!rst_n)
        arith_stat.done |-> (state_reg != S_IDLE && state_reg != S_DONE))
        else $error("shared unit finished outside a compute step");

    // A new command never lands on a unit that is still iterating.
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        arith_cmd.start |-> !arith_stat.busy)
        else $error("shared unit started while busy");

    // A segment behind the camera carries no projection and is never drawn.
    a_behind_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && behind_camera) |->
            (screen_x == 16'sd0 && screen_y == 16'sd0 && depth_scale == '0 && !visible))
        else $error("segment behind camera has a projection");

    // A visible segment lies strictly above the horizon it was tested against.
    a_visible_above: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && visible) |-> (screen_y < clip_line))
        else $error("visible segment not above clip line");

endmodule

@@ rtl/rsp_arith.sv @@
// Shared iterative arithmetic unit: shift-add multiply and restoring divide.
// One 64-bit adder serves both; depends on rsp_pkg.
module rsp_arith
    import rsp_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  arith_cmd_t              cmd,
    output arith_stat_t             stat,
    output logic signed [ACC_W-1:0] result
);

    arith_op_t        op_reg, op_next;
    logic [ACC_W-1:0] acc_reg, acc_next;
    logic [ACC_W-1:0] mcand_reg, mcand_next;
    logic [OPB_W-1:0] mplier_reg, mplier_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;

    logic [ACC_W-1:0] add_x;
    logic [ACC_W-1:0] add_y;
    logic [ACC_W-1:0] add_sum;
    logic             is_div;
    logic             neg;

    // The one adder. A divide step subtracts the divisor from the shifted remainder.
    assign is_div  = (op_reg == OP_DIV);
    assign add_x   = is_div ? {acc_reg[ACC_W-2:0], mcand_reg[ACC_W-1]} : acc_reg;
    assign add_y   = is_div ? ~{{(ACC_W-OPB_W){1'b0}}, mplier_reg} : mcand_reg;
    assign add_sum = add_x + add_y + {{(ACC_W-1){1'b0}}, is_div};
    assign neg     = add_sum[ACC_W-1];

    // Step control: one multiplier bit or one quotient bit per cycle.
    always_comb
    begin
        op_next     = op_reg;
        acc_next    = acc_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        cnt_next    = cnt_reg;
        busy_next   = busy_reg;
        done_next   = 1'b0;
        if (cmd.start)
        begin
            op_next     = cmd.op;
            acc_next    = '0;
            mcand_next  = cmd.a;
            mplier_next = cmd.b;
            cnt_next    = cmd.nbits;
            busy_next   = 1'b1;
        end
        else if (busy_reg)
        begin
            if (is_div)
            begin
                acc_next   = neg ? add_x : add_sum;
                mcand_next = {mcand_reg[ACC_W-2:0], ~neg};
            end
            else
            begin
                acc_next    = mplier_reg[0] ? add_sum : acc_reg;
                mcand_next  = {mcand_reg[ACC_W-2:0], 1'b0};
                mplier_next = {1'b0, mplier_reg[OPB_W-1:1]};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == {{(CNT_W-1){1'b0}}, 1'b1})
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_reg     <= OP_MUL;
            acc_reg    <= '0;
            mcand_reg  <= '0;
            mplier_reg <= '0;
            cnt_reg    <= '0;
            busy_reg   <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            op_reg     <= op_next;
            acc_reg    <= acc_next;
            mcand_reg  <= mcand_next;
            mplier_reg <= mplier_next;
            cnt_reg    <= cnt_next;
            busy_reg   <= busy_next;
            done_reg   <= done_next;
        end
    end

    // After a divide the quotient has shifted fully into the low bits.
    assign result    = is_div ? $signed(mcand_reg) : $signed(acc_reg);
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

@@ tb/road_segment_projector_tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for road_segment_projector: directed segments, then random frames.
// Depends on rsp_pkg and the road_segment_projector RTL with its rsp_arith unit.
module road_segment_projector_tb
    import rsp_pkg::*;
();

    // Segment word as offered on the input channel.
    typedef struct packed {
        logic               frame_start;
        logic signed [23:0] player_x;
        logic signed [15:0] camera_height;
        logic signed [23:0] camera_z;
        logic signed [15:0] center_x;
        logic signed [15:0] center_y;
        logic [22:0]        center_z;
        logic signed [9:0]  bend;
    } seg_t;

    // Projection word as delivered on the output channel.
    typedef struct packed {
        logic signed [15:0] screen_x;
        logic signed [15:0] screen_y;
        logic [15:0]        road_half_width;
        logic [SCALE_W-1:0] depth_scale;
        logic signed [15:0] clip_line;
        logic               visible;
        logic               behind_camera;
    } proj_t;

    // One directed row: the segment and, where it is obvious, its projection.
    typedef struct {
        seg_t  seg;
        bit    typed;
        proj_t want;
    } dir_row_t;

    localparam longint LATERAL_LIM = 64'sd549755813887;
    localparam int     HOLD_CYCLES = 2000;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic                  frame_start = 1'b0;
    logic signed [23:0]    player_x = '0;
    logic signed [15:0]    camera_height = '0;
    logic signed [23:0]    camera_z = '0;
    logic signed [15:0]    center_x = '0;
    logic signed [15:0]    center_y = '0;
    logic [22:0]           center_z = '0;
    logic signed [9:0]     bend = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic signed [15:0]    screen_x;
    logic signed [15:0]    screen_y;
    logic [15:0]           road_half_width;
    logic [SCALE_W-1:0]    depth_scale;
    logic signed [15:0]    clip_line;
    logic                  visible;
    logic                  behind_camera;

    // Shadow of the configuration and of the projector state.
    longint      cfg_sw = SCREEN_WIDTH_RST;
    longint      cfg_sh = SCREEN_HEIGHT_RST;
    longint      cfg_rw = ROAD_WIDTH_RST;
    longint      cfg_cd = CAMERA_DEPTH_RST;
    logic [39:0] lat_offset = '0;
    logic [31:0] lat_rate = '0;
    longint      horizon_q = SCREEN_HEIGHT_RST;

    proj_t pending_projections[$];
    int    tx_idle_pct = 0;
    int    rx_stall_pct = 0;
    logic  hold_start = 1'b0;
    int    hold_left = 0;
    int    mismatch_count = 0;
    int    words_checked = 0;
    int    behind_seen = 0;
    int    visible_seen = 0;
    int    settings_used = 1;

    // Directed segments at the reset configuration.
    dir_row_t directed_rows [18] = '{
        '{'{1, 0, 0, 0, 0, 0, 0, 0}, 1, '{0, 0, 0, 0, 768, 0, 1}},
        '{'{0, 0, 0, 8388607, 0, 0, 0, 256}, 1, '{0, 0, 0, 0, 768, 0, 1}},
        '{'{1, 0, 0, -8388608, 0, 0, 8388607, 0}, 1, '{512, 384, 0, 0, 768, 1, 0}},
        '{'{0, 0, 0, -8388608, 0, 0, 8388607, -256}, 1, '{512, 384, 0, 0, 384, 0, 0}},
        '{'{1, -8388608, -32768, 0, 32767, 32767, 1, 511}, 0, '0},
        '{'{0, 8388607, 32767, 0, -32768, -32768, 1, -512}, 0, '0},
        '{'{0, 0, 0, -1, 0, 0, 0, 0}, 0, '0},
        '{'{0, 1000, 1500, 0, 1000, 0, 8388607, 0}, 0, '0},
        '{'{1, 0, 1500, 1000, 0, 0, 1200, 128}, 0, '0},
        '{'{0, 0, 1500, 1000, 100, 600, 1400, 128}, 0, '0},
        '{'{0, 0, 1500, 1000, 200, 2400, 1600, 0}, 0, '0},
        '{'{0, 0, 1500, 1000, 300, 1800, 1800, -128}, 0, '0},
        '{'{0, 0, 1500, 1000, 200, 900, 2000, -256}, 0, '0},
        '{'{0, 0, 1500, 1000, 0, 4000, 2200, 0}, 0, '0},
        '{'{0, 0, 1500, 1000, -300, -800, 2400, 256}, 0, '0},
        '{'{0, 0, 1500, 1000, 0, 0, 1000, 0}, 0, '0},
        '{'{1, 0, 0, 0, 0, 0, 1, 0}, 1, '{512, 384, 65535, 14092800, 768, 1, 0}},
        '{'{0, -8388608, 0, 8388606, 0, 0, 8388607, 511}, 0, '0}
    };

    road_segment_projector u_top (.*);

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic longint sat16(input longint v);
        return (v > 32767) ? 32767 : ((v < -32768) ? -32768 : v);
    endfunction

    // Projects one segment and advances the curve accumulators and the horizon.
    function automatic proj_t project_segment(input seg_t s);
        longint d, dxq, dy, t, sc, cz, camz, sx, sy;
        longint unsigned num, den, scl, w;
        proj_t r;
        r = '0;
        if (s.frame_start) begin
            lat_offset = '0;
            lat_rate = '0;
            horizon_q = cfg_sh;
        end
        r.clip_line = horizon_q[15:0];
        cz = s.center_z;
        camz = s.camera_z;
        d = cz - camz;
        r.behind_camera = (d <= 0);
        if (d > 0) begin
            num = cfg_cd;
            num = num << SCALE_FRAC_BITS;
            den = d;
            den = den << 16;
            scl = num / den;
            if (scl > 64'hFFFFFF)
                scl = 64'hFFFFFF;
            sc = scl;
            // Lateral distance in Q8, clamped symmetrically before scaling.
            dxq = s.center_x;
            dxq = (dxq - s.player_x) * 256 + $signed(lat_offset);
            if (dxq > LATERAL_LIM)
                dxq = LATERAL_LIM;
            if (dxq < -LATERAL_LIM)
                dxq = -LATERAL_LIM;
            t = (sc * dxq) >>> SCALE_FRAC_BITS;
            sx = sat16(((256 + t) * cfg_sw) >>> 9);
            dy = s.center_y;
            dy = dy - s.camera_height;
            t = (sc * dy) >>> (SCALE_FRAC_BITS - 8);
            sy = sat16(((256 - t) * cfg_sh) >>> 9);
            w = (scl * cfg_rw * cfg_sw) >> (SCALE_FRAC_BITS + 1);
            r.road_half_width = (w > 64'hFFFF) ? 16'hFFFF : w[15:0];
            r.depth_scale = scl[23:0];
            r.screen_x = sx[15:0];
            r.screen_y = sy[15:0];
            // A segment above the current horizon is drawn and lowers the clip.
            if (sy < horizon_q) begin
                r.visible = 1'b1;
                horizon_q = sy;
            end
        end
        lat_offset = lat_offset + {{8{lat_rate[31]}}, lat_rate};
        lat_rate = lat_rate + {{22{s.bend[9]}}, s.bend};
        return r;
    endfunction

    // Offers one segment word, holds it until accepted, then records its projection.
    task automatic send_segment(input seg_t s, input bit typed, input proj_t want);
        int    gap;
        proj_t predicted;
        // Gap lengths span a whole item period so idle stretches hit every point of the work.
        gap = ($urandom_range(0, 99) < tx_idle_pct) ? $urandom_range(1, 160) : 0;
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        frame_start <= s.frame_start;
        player_x <= s.player_x;
        camera_height <= s.camera_height;
        camera_z <= s.camera_z;
        center_x <= s.center_x;
        center_y <= s.center_y;
        center_z <= s.center_z;
        bend <= s.bend;
        do @(posedge clk); while (in_stall);
        predicted = project_segment(s);
        pending_projections.insert(pending_projections.size(), typed ? want : predicted);
    endtask

    // Mostly well-formed frames (near to far, rolling hills, curves), the rest noise.
    task automatic random_segments(input int count);
        seg_t         s;
        int           left, k, seg_len, hill, cam_z, cam_h, ply_x, cz;
        bit           first;
        logic [159:0] noise;
        left = 0;
        k = 0;
        seg_len = 0;
        hill = 0;
        cam_z = 0;
        cam_h = 0;
        ply_x = 0;
        first = 1'b0;
        for (int i = 0; i < count; i++) begin
            if (left == 0) begin
                left = $urandom_range(1, 40);
                k = -$urandom_range(0, 2);
                seg_len = $urandom_range(20, 600);
                cam_z = $urandom_range(0, 4000000);
                cam_h = $urandom_range(0, 3000);
                ply_x = $urandom_range(0, 6000) - 3000;
                hill = 0;
                first = 1'b1;
            end
            if ($urandom_range(0, 99) < 25) begin
                noise = {$urandom, $urandom, $urandom, $urandom, $urandom};
                s = noise[$bits(seg_t)-1:0];
            end
            else begin
                hill = hill + $urandom_range(0, 800) - 400;
                if (hill > 30000 || hill < -30000)
                    hill = 0;
                cz = cam_z + k * seg_len;
                s.frame_start = first;
                s.player_x = 24'(ply_x);
                s.camera_height = 16'(cam_h);
                s.camera_z = 24'(cam_z);
                s.center_x = 16'($urandom_range(0, 400) - 200);
                s.center_y = 16'(hill);
                s.center_z = 23'((cz < 0) ? 0 : cz);
                s.bend = 10'(($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 512) - 256);
                first = 1'b0;
                k++;
                left--;
            end
            send_segment(s, 1'b0, '0);
        end
    endtask

    // Drains the block, then rewrites every register and changes the idling mode.
    task automatic new_phase(input int sw, input int sh, input int rw, input int cd,
                             input int tx_pct, input int rx_pct);
        in_valid <= 1'b0;
        while (pending_projections.size() != 0) @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= CFG_SCREEN_WIDTH;
        cfg_data <= CFG_DATA_W'(sw);
        @(posedge clk);
        cfg_index <= CFG_SCREEN_HEIGHT;
        cfg_data <= CFG_DATA_W'(sh);
        @(posedge clk);
        cfg_index <= CFG_ROAD_WIDTH;
        cfg_data <= CFG_DATA_W'(rw);
        @(posedge clk);
        cfg_index <= CFG_CAMERA_DEPTH;
        cfg_data <= CFG_DATA_W'(cd);
        @(posedge clk);
        cfg_write <= 1'b0;
        cfg_sw = sw & 'h1FFF;
        cfg_sh = sh & 'h1FFF;
        cfg_rw = rw & 'hFFFF;
        cfg_cd = cd & 'h3FFFF;
        tx_idle_pct = tx_pct;
        rx_stall_pct <= rx_pct;
        settings_used++;
    endtask

    // Output stall: random per cycle, or one long hold-off on request.
    always @(posedge clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
            hold_left <= 0;
        end
        else if (hold_start) begin
            hold_left <= HOLD_CYCLES;
            out_stall <= 1'b1;
        end
        else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else begin
            out_stall <= ($urandom_range(0, 99) < rx_stall_pct);
        end
    end

    // Each accepted projection word is compared with the oldest expectation.
    always @(posedge clk) begin
        proj_t got, want;
        if (rst_n && out_valid && !out_stall) begin
            got = '{screen_x, screen_y, road_half_width, depth_scale, clip_line,
                    visible, behind_camera};
            if (pending_projections.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("Unexpected projection word at %0t ns", $time);
            end
            else begin
                want = pending_projections.pop_front();
                words_checked++;
                behind_seen += got.behind_camera;
                visible_seen += got.visible;
                if (got !== want) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("Word %0d expected x=%0d y=%0d half=%0d scale=%0d clip=%0d vis=%b bh=%b",
                                 words_checked, want.screen_x, want.screen_y,
                                 want.road_half_width, want.depth_scale, want.clip_line,
                                 want.visible, want.behind_camera);
                        $display("        actual   x=%0d y=%0d half=%0d scale=%0d clip=%0d vis=%b bh=%b",
                                 got.screen_x, got.screen_y, got.road_half_width,
                                 got.depth_scale, got.clip_line, got.visible,
                                 got.behind_camera);
                    end
                end
            end
        end
    end

    // Main sequence: reset, directed rows, then random frames under several settings.
    initial begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[r])
            send_segment(directed_rows[r].seg, directed_rows[r].typed, directed_rows[r].want);
        random_segments(140);

        new_phase(4096, 4096, 65535, 262143, 63, 0);
        random_segments(160);
        new_phase(1, 1, 0, 0, 0, 63);
        random_segments(160);
        new_phase(0, 0, 65535, 55050, 23, 23);
        random_segments(160);

        // Long receiver hold-off while segments keep coming, so the block backs up.
        new_phase($urandom_range(1, 4096), $urandom_range(1, 4096), $urandom_range(0, 65535),
                  $urandom_range(0, 262143), 0, 0);
        hold_start <= 1'b1;
        @(posedge clk);
        hold_start <= 1'b0;
        random_segments(160);

        new_phase(1024, 768, 2000, 55050, 0, 0);
        random_segments(160);

        in_valid <= 1'b0;
        while (pending_projections.size() != 0) @(posedge clk);
        repeat (150) @(posedge clk);
        $display("Checked %0d projections under %0d register settings.",
                 words_checked, settings_used);
        $display("%0d segments were behind the camera, %0d cleared the horizon.",
                 behind_seen, visible_seen);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Watchdog well beyond the slowest legal run.
    initial begin
        #20000000;
        $display("Timed out with %0d projections outstanding.", pending_projections.size());
        $display("Mismatches found");
        $finish;
    end

endmodule
